// File: hw/rtl/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg: shared types and constants of the equal-power crossfade
// Fixed sample and gain widths, polynomial coefficients of the quarter-sine
// gain curve, register indexes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ecf_pkg;

    // Fixed sizes of the stream and the fade
    localparam int SAMPLE_BITS = 24;
    localparam int DATA_W      = 24;
    localparam int LEN_W       = 22;
    localparam int MAX_FADE    = 2097152;
    localparam int PHASE_BITS  = 10;
    localparam int K_W         = PHASE_BITS + 1;

    // Gain polynomial: Q30 argument, Q15 result
    localparam int FRAC_W      = 30;
    localparam int COEF_W      = 31;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int T_W         = PROD_W - FRAC_W;
    localparam int GAIN_W      = 15;
    localparam int ACC_W       = 41;
    localparam int MIX_W       = DATA_W + GAIN_W + 1;

    localparam logic [COEF_W-1:0] COEF1 = 31'd1686629713;
    localparam logic [COEF_W-1:0] COEF3 = 31'd693598668;
    localparam logic [COEF_W-1:0] COEF5 = 31'd85569306;
    localparam logic [COEF_W-1:0] COEF7 = 31'd5026995;
    localparam logic [COEF_W-1:0] COEF9 = 31'd172272;

    // Sequencer step counts
    localparam int DIV_STEPS  = PHASE_BITS;
    localparam int GAIN_STEPS = 7;
    localparam int CNT_W      = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 2'd2;

    // Gain unit operations, one per cycle
    typedef enum logic [2:0] {
        GOP_NONE,
        GOP_X2,
        GOP_T9,
        GOP_T7,
        GOP_T5,
        GOP_T3,
        GOP_S,
        GOP_G
    } t_gop;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        t_gop gop;
        logic mix_c;
        logic mix_s;
        logic out_load;
        logic out_mixed;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fade;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/ecf_gain.sv
// ----------------------------------------------------------------------------
// ecf_gain: quarter-sine gain unit
// Evaluates sin(pi/2 * k / 2^PHASE_BITS) in Q15 with a Horner polynomial,
// one multiply per cycle through a single 31x31 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_gain (
    input  wire logic                       i_clk,
    input  wire ecf_pkg::t_gop              i_op,
    input  wire logic [ecf_pkg::K_W-1:0]    i_k,
    output logic      [ecf_pkg::GAIN_W-1:0] o_gain
);

    localparam int SHIFT = ecf_pkg::FRAC_W - ecf_pkg::PHASE_BITS;
    localparam int SUM_W = ecf_pkg::T_W + 1;
    localparam int PW    = ecf_pkg::PROD_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(16384);
    localparam logic [SUM_W-1:0] GAIN_MAX   = SUM_W'(32767);

    logic [ecf_pkg::COEF_W-1:0] w_x;
    logic [ecf_pkg::COEF_W-1:0] w_opa;
    logic [ecf_pkg::COEF_W-1:0] w_opb;
    logic [ecf_pkg::PROD_W-1:0] w_prod;
    logic [ecf_pkg::COEF_W-1:0] w_t;
    logic [SUM_W-1:0]           w_sum;
    logic [SUM_W-1:0]           w_round;

    logic [ecf_pkg::COEF_W-1:0] r_x2;
    logic [ecf_pkg::T_W-1:0]    r_t;
    logic [ecf_pkg::GAIN_W-1:0] r_gain;

    // Scale the phase to Q30
    assign w_x = {i_k, {SHIFT{1'b0}}};
    assign w_t = r_t[ecf_pkg::COEF_W-1:0];

    // Select multiplier operands for this Horner step
    always_comb begin
        w_opa = w_x;
        w_opb = r_x2;
        case (i_op)
            ecf_pkg::GOP_X2: begin
                w_opa = w_x;
                w_opb = w_x;
            end
            ecf_pkg::GOP_T9: w_opa = ecf_pkg::COEF9;
            ecf_pkg::GOP_T7: w_opa = ecf_pkg::COEF7 - w_t;
            ecf_pkg::GOP_T5: w_opa = ecf_pkg::COEF5 - w_t;
            ecf_pkg::GOP_T3: w_opa = ecf_pkg::COEF3 - w_t;
            ecf_pkg::GOP_S: begin
                w_opa = ecf_pkg::COEF1 - w_t;
                w_opb = w_x;
            end
            default: begin
                w_opa = w_x;
                w_opb = r_x2;
            end
        endcase
    end

    assign w_prod  = PW'(w_opa) * PW'(w_opb);
    assign w_sum   = {1'b0, r_t} + ROUND_HALF;
    assign w_round = SUM_W'(w_sum >> 15);

    // Register each product, then round and cap the sum to Q15
    always_ff @(posedge i_clk) begin
        case (i_op)
            ecf_pkg::GOP_X2: r_x2 <= w_prod[ecf_pkg::FRAC_W +: ecf_pkg::COEF_W];
            ecf_pkg::GOP_T9,
            ecf_pkg::GOP_T7,
            ecf_pkg::GOP_T5,
            ecf_pkg::GOP_T3,
            ecf_pkg::GOP_S: r_t <= w_prod[ecf_pkg::FRAC_W +: ecf_pkg::T_W];
            ecf_pkg::GOP_G: begin
                if (w_round > GAIN_MAX) begin
                    r_gain <= GAIN_MAX[ecf_pkg::GAIN_W-1:0];
                end else begin
                    r_gain <= w_round[ecf_pkg::GAIN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_gain = r_gain;

endmodule

`default_nettype wire

// File: hw/rtl/ecf_dp.sv
// ----------------------------------------------------------------------------
// ecf_dp: crossfade datapath
// Configuration registers, position counter, restoring phase divider, two
// gain units, the mixing accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ecf_pkg::t_cmd                 i_cmd,
    output ecf_pkg::t_sts                      o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [ecf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ecf_pkg::LEN_W-1:0]     i_cfg_data,
    input  wire logic [ecf_pkg::DATA_W-1:0]    i_next,
    input  wire logic [ecf_pkg::DATA_W-1:0]    i_tail,
    input  wire logic                          i_start,
    output logic      [ecf_pkg::DATA_W-1:0]    o_mixed,
    output logic                               o_in_fade
);

    localparam int LW = ecf_pkg::LEN_W;
    localparam int AW = ecf_pkg::ACC_W;
    localparam int PW = ecf_pkg::PHASE_BITS;
    localparam int KW = ecf_pkg::K_W;
    localparam int DW = ecf_pkg::DATA_W;
    localparam int MW = ecf_pkg::MIX_W;

    localparam logic [LW-1:0] MAX_LEN    = LW'(ecf_pkg::MAX_FADE);
    localparam logic [LW-1:0] FADE_RST   = LW'(176400);
    localparam logic [LW-1:0] OUTLEN_RST = LW'(2097152);
    localparam logic [KW-1:0] K_FULL     = KW'(1 << PW);
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(16384);
    localparam logic signed [AW-1:0] SAT_HI =
        AW'((64'sd1 <<< (ecf_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    // Configuration and counter state
    logic          r_enable;
    logic [LW-1:0] r_fade;
    logic [LW-1:0] r_out_len;
    logic [LW-1:0] r_position;

    // Per-item payload
    logic signed [DW-1:0] r_next;
    logic signed [DW-1:0] r_tail;
    logic [LW-1:0]        r_pos;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_rem;
    logic [PW-1:0]        r_phase;
    logic signed [AW-1:0] r_acc;
    logic [DW-1:0]        r_mixed;
    logic                 r_in_fade;

    logic [LW-1:0]                   w_pos_eff;
    logic [LW-1:0]                   n_position;
    logic [LW-1:0]                   w_len_a;
    logic [LW-1:0]                   w_len;
    logic [LW:0]                     w_rem2;
    logic [LW:0]                     w_diff;
    logic                            w_ge;
    logic [KW-1:0]                   w_k_sin;
    logic [KW-1:0]                   w_k_cos;
    logic [ecf_pkg::GAIN_W-1:0]      w_gain_sin;
    logic [ecf_pkg::GAIN_W-1:0]      w_gain_cos;
    logic signed [ecf_pkg::MIX_W-1:0] w_prod_c;
    logic signed [ecf_pkg::MIX_W-1:0] w_prod_s;
    logic signed [AW-1:0]            w_shift;
    logic signed [AW-1:0]            w_pass;

    // Clamp a wide signed value to the sample range
    function automatic logic [DW-1:0] sat_sample(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[DW-1:0];
    endfunction

    // Restart position on a start item; saturate at the fade limit
    assign w_pos_eff  = i_start ? '0 : r_position;
    assign n_position = (w_pos_eff < MAX_LEN) ? w_pos_eff + LW'(1) : w_pos_eff;

    // Fade length is the smallest of the two registers and the limit
    assign w_len_a = (r_out_len < r_fade) ? r_out_len : r_fade;
    assign w_len   = (w_len_a > MAX_LEN) ? MAX_LEN : w_len_a;

    assign o_sts.fade = r_enable && (r_len != '0) && (r_pos < r_len);

    // One quotient bit per step
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_len};
    assign w_diff = w_rem2 - {1'b0, r_len};

    assign w_k_sin = {1'b0, r_phase};
    assign w_k_cos = K_FULL - w_k_sin;

    ecf_gain u_gain_sin (
        .i_clk  (i_clk),
        .i_op   (i_cmd.gop),
        .i_k    (w_k_sin),
        .o_gain (w_gain_sin)
    );

    ecf_gain u_gain_cos (
        .i_clk  (i_clk),
        .i_op   (i_cmd.gop),
        .i_k    (w_k_cos),
        .o_gain (w_gain_cos)
    );

    assign w_prod_c = MW'(r_tail) * MW'($signed({1'b0, w_gain_cos}));
    assign w_prod_s = MW'(r_next) * MW'($signed({1'b0, w_gain_sin}));
    assign w_shift  = r_acc >>> 15;
    assign w_pass   = AW'(r_next);

    // Control state: configuration and position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_fade     <= FADE_RST;
            r_out_len  <= OUTLEN_RST;
            r_position <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ecf_pkg::REG_ENABLE:  r_enable  <= i_cfg_data[0];
                    ecf_pkg::REG_FADE:    r_fade    <= i_cfg_data;
                    ecf_pkg::REG_OUT_LEN: r_out_len <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_position <= n_position;
            end
        end
    end

    // Payload: capture, divide, mix and hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_next <= i_next;
            r_tail <= i_tail;
            r_pos  <= w_pos_eff;
            r_rem  <= w_pos_eff;
            r_len  <= w_len;
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_diff[LW-1:0] : w_rem2[LW-1:0];
            r_phase <= {r_phase[PW-2:0], w_ge};
        end
        if (i_cmd.mix_c) begin
            r_acc <= AW'(w_prod_c);
        end
        if (i_cmd.mix_s) begin
            r_acc <= r_acc + AW'(w_prod_s) + ROUND_HALF;
        end
        if (i_cmd.out_load) begin
            r_mixed   <= i_cmd.out_mixed ? sat_sample(w_shift) : sat_sample(w_pass);
            r_in_fade <= i_cmd.out_mixed;
        end
    end

    assign o_mixed   = r_mixed;
    assign o_in_fade = r_in_fade;

endmodule

`default_nettype wire

// File: hw/rtl/ecf_ctrl.sv
// ----------------------------------------------------------------------------
// ecf_ctrl: crossfade controller
// Sequences one item through decide, divide, gain, mix and output steps
// (only decide and output outside the fade); owns input ready and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ecf_pkg::t_cmd      o_cmd,
    input  wire ecf_pkg::t_sts i_sts
);

    localparam int CW = ecf_pkg::CNT_W;
    localparam logic [CW-1:0] DIV_LAST  = CW'(ecf_pkg::DIV_STEPS - 1);
    localparam logic [CW-1:0] GAIN_LAST = CW'(ecf_pkg::GAIN_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_GAIN,
        S_MIX_C,
        S_MIX_S,
        S_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_mixed;
    logic          n_mixed;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          w_accept;
    logic          w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mixed     = r_mixed;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.gop   = ecf_pkg::GOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cnt   = '0;
                n_mixed = i_sts.fade;
                n_state = i_sts.fade ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                case (r_cnt)
                    CW'(0):  o_cmd.gop = ecf_pkg::GOP_X2;
                    CW'(1):  o_cmd.gop = ecf_pkg::GOP_T9;
                    CW'(2):  o_cmd.gop = ecf_pkg::GOP_T7;
                    CW'(3):  o_cmd.gop = ecf_pkg::GOP_T5;
                    CW'(4):  o_cmd.gop = ecf_pkg::GOP_T3;
                    CW'(5):  o_cmd.gop = ecf_pkg::GOP_S;
                    CW'(6):  o_cmd.gop = ecf_pkg::GOP_G;
                    default: o_cmd.gop = ecf_pkg::GOP_NONE;
                endcase
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == GAIN_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MIX_C;
                end
            end
            S_MIX_C: begin
                o_cmd.mix_c = 1'b1;
                n_state     = S_MIX_S;
            end
            S_MIX_S: begin
                o_cmd.mix_s = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register is free
                if (w_out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_mixed = r_mixed;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mixed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mixed     <= n_mixed;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/equal_power_crossfade.sv
// ----------------------------------------------------------------------------
// equal_power_crossfade: equal-power sine/cosine crossfade of two tracks
// Mixes each incoming sample with the aligned tail sample of the outgoing
// track using quarter-sine gains, or passes the incoming sample through.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis: one item per interleaved sample; tdata carries the
//    incoming and the outgoing tail sample, tuser flags the first sample of
//    the incoming track (restarts the position counter).
//  - Output stream m_axis: one item per input item, in order; tdata is the
//    mixed sample, tuser is set when the sample was mixed inside the fade.
//  - Config channel: writes enable, fade length and outgoing length by
//    index; always ready; write only while no item is in flight.
//  - Sequence: an accepted mixed item passes a decide step, 10 divider
//    steps for the phase, 7 gain-polynomial steps, the cos and sin mix
//    steps and an output step; a pass-through item goes from decide to
//    output. A new item is taken only once the last has left, so inside
//    the fade the rate is set by the one-bit-per-cycle phase divider and
//    the shared multiplier in each gain unit.
//  - Reset clears the position counter, the output valid flag and restores
//    the register defaults (disabled, fade 176400, outgoing 2097152).
//  - When the receiver stalls, the result is held in the output register; a
//    new item is still accepted and processed, then waits for that slot.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_power_crossfade (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [23:0] next_sample, [47:24] tail_sample
    input  wire logic [2*ecf_pkg::DATA_W-1:0]      s_axis_tdata,
    // [0] start_req
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [23:0] mixed_sample
    output logic      [ecf_pkg::DATA_W-1:0]        m_axis_tdata,
    // [0] in_fade
    output logic                                   m_axis_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ecf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ecf_pkg::LEN_W-1:0]         i_cfg_data
);

    localparam int DW = ecf_pkg::DATA_W;

    ecf_pkg::t_cmd w_cmd;
    ecf_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ecf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ecf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_next      (s_axis_tdata[DW-1:0]),
        .i_tail      (s_axis_tdata[2*DW-1:DW]),
        .i_start     (s_axis_tuser),
        .o_mixed     (m_axis_tdata),
        .o_in_fade   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: hw/rtl/ecf_checker.sv
// ----------------------------------------------------------------------------
// ecf_checker: port-level checks of the crossfade
// Watches the stream ports for reset behavior, output hold under stall and
// the busy period that follows each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    input  wire logic [ecf_pkg::DATA_W-1:0]   i_m_tdata,
    input  wire logic                         i_m_tuser
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled output item changed");

    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after an accept");

    // A fresh result is only written from the busy output step
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> !$past(i_s_tready))
        else $error("result appeared without a finished item");

endmodule

bind equal_power_crossfade ecf_checker u_ecf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire
